// ===== src/blsq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blsq_pkg: shared types and constants for the least-squares trend block
// Field widths, internal datapath widths and the trend code.
// ----------------------------------------------------------------------------
package blsq_pkg;

    // Port field widths
    localparam int SAMPLE_W   = 24;
    localparam int SLOPE_W    = 40;
    localparam int CNT_W      = 7;
    localparam int MAX_WINDOW = 64;
    localparam int WL_RESET   = 10;
    localparam int FRAC_BITS  = 8;

    // Running sums and derived terms
    localparam int SUM_W  = 31;   // sum of samples
    localparam int WSUM_W = 36;   // sum of position * sample
    localparam int SX_W   = 12;   // sum of positions
    localparam int SXX_W  = 17;   // sum of squared positions

    // Shared multiplier
    localparam int MUL_A_W = 13;
    localparam int MUL_B_W = 36;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Numerator, denominator and divider
    localparam int NUM_W      = 43;
    localparam int MAG_W      = 42;
    localparam int DEN_W      = 21;
    localparam int DIVISOR_W  = DEN_W + 1;                    // twice the denominator
    localparam int QUO_W      = SLOPE_W;                      // quotient bits developed
    localparam int DIVIDEND_W = MAG_W + FRAC_BITS + 2;        // 2^(F+1)*|num| + den
    localparam int HEAD_W     = DIVIDEND_W - QUO_W;           // dividend bits above quotient
    localparam int STEP_CNT_W = 6;

    // Saturation limits of the slope magnitude
    localparam logic [QUO_W-1:0] CAP_POS = {1'b0, {(QUO_W-1){1'b1}}};
    localparam logic [QUO_W-1:0] CAP_NEG = {1'b1, {(QUO_W-1){1'b0}}};

    // Trend code
    typedef enum logic [1:0] {
        TREND_FLAT    = 2'd0,
        TREND_RISING  = 2'd1,
        TREND_FALLING = 2'd2,
        TREND_UNDEF   = 2'd3
    } trend_t;

endpackage

// ===== src/block_least_squares_trend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_least_squares_trend: least-squares slope of one sensor channel
// Sequencer around one shared multiplier and a radix-2 restoring divider.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready, sample): one item per sensor sample.
//    The sample takes position n = 1, 2, ... within the current window.
//  - Output channel (out_valid/out_ready): one item per sample with the slope
//    (8 fraction bits, rounded half away from zero, saturated), trend code,
//    position n and a window-closed flag.
//  - cfg_write_en/cfg_write_data set the window length (reset 10, capped at
//    64; 0 or 1 close the window on every sample). Write only while idle.
// Timing:
//  - An item runs from acceptance to out_valid through 6 steps on the
//    shared multiplier, 2 setup steps, 40 divider steps (one quotient bit
//    each) and 1 output load; a single-sample item skips the divider.
//    in_ready is high only in idle: a new item waits until the last one loads.
//  - The result sits in an output register, so the next item is taken while
//    it waits; if the receiver still stalls when the next result is ready,
//    the sequencer holds it until the register frees.
// Reset: clears the count, the sums and any pending result; window length
//  returns to 10.
// ----------------------------------------------------------------------------
module block_least_squares_trend
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_write_en,
    input  logic [blsq_pkg::CNT_W-1:0]           cfg_write_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [blsq_pkg::SAMPLE_W-1:0] sample,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [blsq_pkg::SLOPE_W-1:0]  slope,
    output logic [1:0]                           trend,
    output logic [blsq_pkg::CNT_W-1:0]           samples_used,
    output logic                                 window_closed
);

    typedef enum logic [3:0] {
        S_IDLE, S_WY, S_NN, S_P1, S_P2, S_P3, S_P4, S_PREP, S_LOAD, S_DIV, S_FIN
    } state_t;

    state_t state_reg, state_next;

    // Configuration and window state
    logic [blsq_pkg::CNT_W-1:0]         wl_reg;
    logic [blsq_pkg::CNT_W-1:0]         count_reg;
    logic signed [blsq_pkg::SUM_W-1:0]  value_sum_reg;
    logic signed [blsq_pkg::WSUM_W-1:0] weighted_sum_reg;
    logic [blsq_pkg::SX_W-1:0]          sx_acc_reg;
    logic [blsq_pkg::SXX_W-1:0]         sxx_acc_reg;

    // Per-item working registers
    logic signed [blsq_pkg::SAMPLE_W-1:0] y_reg;
    logic [blsq_pkg::CNT_W-1:0]           n_reg;
    logic                                 closed_reg;
    logic signed [blsq_pkg::SUM_W-1:0]    sy_reg;
    logic signed [blsq_pkg::WSUM_W-1:0]   sxy_reg;
    logic [blsq_pkg::SX_W-1:0]            sx_reg;
    logic [blsq_pkg::SXX_W-1:0]           sxx_reg;
    logic signed [blsq_pkg::NUM_W-1:0]    acc_reg;
    logic signed [blsq_pkg::NUM_W-1:0]    num_reg;
    logic [blsq_pkg::DEN_W-1:0]           den_reg;
    logic [blsq_pkg::MAG_W-1:0]           mag_reg;
    logic                                 neg_reg;
    logic                                 undef_reg;
    blsq_pkg::trend_t                     trend_reg;
    logic [blsq_pkg::DIVISOR_W-1:0]       d2_reg;
    logic                                 sat_reg;
    logic [blsq_pkg::DIVISOR_W-1:0]       rem_reg;
    logic [blsq_pkg::QUO_W-1:0]           quo_reg;
    logic [blsq_pkg::STEP_CNT_W-1:0]      step_reg;

    // Output registers
    logic                                 out_valid_reg;
    logic signed [blsq_pkg::SLOPE_W-1:0]  slope_reg;
    blsq_pkg::trend_t                     trend_out_reg;
    logic [blsq_pkg::CNT_W-1:0]           used_reg;
    logic                                 closed_out_reg;

    // Combinational helpers
    logic [blsq_pkg::CNT_W-1:0]           limit;
    logic [blsq_pkg::CNT_W-1:0]           n_new;
    logic signed [blsq_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [blsq_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [blsq_pkg::PROD_W-1:0]   prod;
    logic signed [blsq_pkg::SUM_W-1:0]    sy_sum;
    logic signed [blsq_pkg::WSUM_W-1:0]   sxy_sum;
    logic [blsq_pkg::SX_W-1:0]            sx_sum;
    logic [blsq_pkg::SXX_W-1:0]           sxx_sum;
    logic [blsq_pkg::DIVIDEND_W-1:0]      dividend;
    logic [blsq_pkg::DIVISOR_W:0]         trial;
    logic                                 trial_ge;
    logic [blsq_pkg::QUO_W-1:0]           cap;
    logic [blsq_pkg::QUO_W-1:0]           mag_sat;
    logic [blsq_pkg::SLOPE_W-1:0]         slope_val;
    logic                                 out_free;
    logic                                 out_load;

    localparam logic [blsq_pkg::CNT_W-1:0] MAX_WIN =
        blsq_pkg::CNT_W'(blsq_pkg::MAX_WINDOW);
    localparam logic [blsq_pkg::STEP_CNT_W-1:0] LAST_STEP =
        blsq_pkg::STEP_CNT_W'(blsq_pkg::QUO_W - 1);

    // Window limit and next position
    assign limit = (wl_reg > MAX_WIN) ? MAX_WIN : wl_reg;
    assign n_new = count_reg + 1'b1;

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = blsq_pkg::MUL_A_W'(n_reg);
        mul_b = blsq_pkg::MUL_B_W'(y_reg);
        unique case (state_reg)
            S_WY:    mul_b = blsq_pkg::MUL_B_W'(y_reg);
            S_NN:    mul_b = blsq_pkg::MUL_B_W'(n_reg);
            S_P1:    mul_b = sxy_reg;
            S_P2:
            begin
                mul_a = blsq_pkg::MUL_A_W'(sx_reg);
                mul_b = blsq_pkg::MUL_B_W'(sy_reg);
            end
            S_P3:    mul_b = blsq_pkg::MUL_B_W'(sxx_reg);
            S_P4:
            begin
                mul_a = blsq_pkg::MUL_A_W'(sx_reg);
                mul_b = blsq_pkg::MUL_B_W'(sx_reg);
            end
            default: mul_b = blsq_pkg::MUL_B_W'(y_reg);
        endcase
    end

    assign prod = mul_a * mul_b;

    // Running sums including this item
    assign sy_sum  = value_sum_reg + blsq_pkg::SUM_W'(y_reg);
    assign sxy_sum = weighted_sum_reg + prod[blsq_pkg::WSUM_W-1:0];
    assign sx_sum  = sx_acc_reg + blsq_pkg::SX_W'(n_reg);
    assign sxx_sum = sxx_acc_reg + prod[blsq_pkg::SXX_W-1:0];

    // Dividend 2^(F+1)*|num| + den, divisor 2*den: rounds half away from zero
    assign dividend = (blsq_pkg::DIVIDEND_W'(mag_reg) << (blsq_pkg::FRAC_BITS + 1))
                    + blsq_pkg::DIVIDEND_W'(den_reg);

    // Restoring divider step
    assign trial    = {rem_reg, quo_reg[blsq_pkg::QUO_W-1]};
    assign trial_ge = trial >= {1'b0, d2_reg};

    // Saturate and apply sign
    assign cap       = neg_reg ? blsq_pkg::CAP_NEG : blsq_pkg::CAP_POS;
    assign mag_sat   = (sat_reg || (quo_reg > cap)) ? cap : quo_reg;
    assign slope_val = undef_reg ? '0 : (neg_reg ? (~mag_sat + 1'b1) : mag_sat);
    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = (state_reg == S_FIN) && out_free;

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_WY;
            S_WY:    state_next = S_NN;
            S_NN:    state_next = S_P1;
            S_P1:    state_next = S_P2;
            S_P2:    state_next = S_P3;
            S_P3:    state_next = S_P4;
            S_P4:    state_next = S_PREP;
            S_PREP:  state_next = (den_reg == '0) ? S_FIN : S_LOAD;
            S_LOAD:  state_next = S_DIV;
            S_DIV:   if (step_reg == '0) state_next = S_FIN;
            S_FIN:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // State, datapath and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            wl_reg           <= blsq_pkg::CNT_W'(blsq_pkg::WL_RESET);
            count_reg        <= '0;
            value_sum_reg    <= '0;
            weighted_sum_reg <= '0;
            sx_acc_reg       <= '0;
            sxx_acc_reg      <= '0;
            y_reg            <= '0;
            n_reg            <= '0;
            closed_reg       <= 1'b0;
            sy_reg           <= '0;
            sxy_reg          <= '0;
            sx_reg           <= '0;
            sxx_reg          <= '0;
            acc_reg          <= '0;
            num_reg          <= '0;
            den_reg          <= '0;
            mag_reg          <= '0;
            neg_reg          <= 1'b0;
            undef_reg        <= 1'b0;
            trend_reg        <= blsq_pkg::TREND_UNDEF;
            d2_reg           <= '0;
            sat_reg          <= 1'b0;
            rem_reg          <= '0;
            quo_reg          <= '0;
            step_reg         <= '0;
            out_valid_reg    <= 1'b0;
            slope_reg        <= '0;
            trend_out_reg    <= blsq_pkg::TREND_UNDEF;
            used_reg         <= '0;
            closed_out_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write_en)
                wl_reg <= cfg_write_data;

            // result taken by the receiver, unless the next one loads now
            if (out_valid_reg && out_ready && !out_load)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        y_reg      <= sample;
                        n_reg      <= n_new;
                        closed_reg <= (n_new >= limit);
                    end
                end
                S_WY:
                begin
                    // n*y and the running sums; window state advances or clears
                    sy_reg  <= sy_sum;
                    sxy_reg <= sxy_sum;
                    sx_reg  <= sx_sum;
                    if (closed_reg)
                    begin
                        count_reg        <= '0;
                        value_sum_reg    <= '0;
                        weighted_sum_reg <= '0;
                        sx_acc_reg       <= '0;
                    end
                    else
                    begin
                        count_reg        <= n_reg;
                        value_sum_reg    <= sy_sum;
                        weighted_sum_reg <= sxy_sum;
                        sx_acc_reg       <= sx_sum;
                    end
                end
                S_NN:
                begin
                    sxx_reg     <= sxx_sum;
                    sxx_acc_reg <= closed_reg ? '0 : sxx_sum;
                end
                S_P1: acc_reg <= blsq_pkg::NUM_W'(prod);
                S_P2: num_reg <= acc_reg - blsq_pkg::NUM_W'(prod);
                S_P3: acc_reg <= blsq_pkg::NUM_W'(prod);
                S_P4: den_reg <= blsq_pkg::DEN_W'(acc_reg - blsq_pkg::NUM_W'(prod));
                S_PREP:
                begin
                    neg_reg   <= num_reg[blsq_pkg::NUM_W-1];
                    mag_reg   <= num_reg[blsq_pkg::NUM_W-1] ?
                                 blsq_pkg::MAG_W'(-num_reg) : blsq_pkg::MAG_W'(num_reg);
                    undef_reg <= (den_reg == '0);
                    d2_reg    <= {den_reg, 1'b0};
                    priority if (den_reg == '0)
                        trend_reg <= blsq_pkg::TREND_UNDEF;
                    else if (num_reg == '0)
                        trend_reg <= blsq_pkg::TREND_FLAT;
                    else if (num_reg[blsq_pkg::NUM_W-1])
                        trend_reg <= blsq_pkg::TREND_FALLING;
                    else
                        trend_reg <= blsq_pkg::TREND_RISING;
                end
                S_LOAD:
                begin
                    // quotient at or above 2^QUO_W saturates outright
                    sat_reg  <= blsq_pkg::DIVISOR_W'(
                                dividend[blsq_pkg::DIVIDEND_W-1:blsq_pkg::QUO_W]) >= d2_reg;
                    rem_reg  <= blsq_pkg::DIVISOR_W'(
                                dividend[blsq_pkg::DIVIDEND_W-1:blsq_pkg::QUO_W]);
                    quo_reg  <= dividend[blsq_pkg::QUO_W-1:0];
                    step_reg <= LAST_STEP;
                end
                S_DIV:
                begin
                    rem_reg  <= trial_ge ? blsq_pkg::DIVISOR_W'(trial - {1'b0, d2_reg})
                                         : blsq_pkg::DIVISOR_W'(trial);
                    quo_reg  <= {quo_reg[blsq_pkg::QUO_W-2:0], trial_ge};
                    step_reg <= step_reg - 1'b1;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        slope_reg      <= slope_val;
                        trend_out_reg  <= trend_reg;
                        used_reg       <= n_reg;
                        closed_out_reg <= closed_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign slope         = slope_reg;
    assign trend         = trend_out_reg;
    assign samples_used  = used_reg;
    assign window_closed = closed_out_reg;

endmodule

// ===== src/blsq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blsq_checker: port-level checks for the least-squares trend block
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module blsq_checker
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [blsq_pkg::SLOPE_W-1:0]  slope,
    input logic [1:0]                           trend,
    input logic [blsq_pkg::CNT_W-1:0]           samples_used,
    input logic                                 window_closed
);

    // one item at a time: an accepted item blocks the input next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after an accepted item");

    // undefined trend exactly for the first sample of a window, with zero slope
    a_undef_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (((trend == blsq_pkg::TREND_UNDEF) == (samples_used == 7'd1))
                       && ((trend != blsq_pkg::TREND_UNDEF) || (slope == '0))))
        else $error("undefined trend does not match a single-sample item");

    // the longest window always closes
    a_full_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (samples_used == 7'(blsq_pkg::MAX_WINDOW))) |-> window_closed)
        else $error("window at maximum length not closed");

    // flat trend carries a zero slope
    a_flat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (trend == blsq_pkg::TREND_FLAT)) |-> (slope == '0))
        else $error("flat trend with nonzero slope");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(slope) && $stable(trend)))
        else $error("stalled result changed");

endmodule

bind block_least_squares_trend blsq_checker u_blsq_checker (.*);
